// ===== design/afd_pkg.sv =====
// ----------------------------------------------------------------------------
// afd_pkg: shared types and constants of the api frame deframer
// framing constants, field widths and the result record
// ----------------------------------------------------------------------------
package afd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 9;

  localparam logic [ByteW-1:0] DelimValue = 8'h7E;
  localparam logic [ByteW-1:0] SumTarget  = 8'hFF;

  // frame offsets with a fixed meaning
  localparam logic [PosW-1:0] PosDelim  = 9'd0;
  localparam logic [PosW-1:0] PosLenLo  = 9'd2;
  localparam logic [PosW-1:0] PosType   = 9'd3;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [PosW-1:0]  byte_position;
    logic             frame_end;
    logic [ByteW-1:0] frame_type;
    logic [ByteW-1:0] payload_length;
    logic             delimiter_ok;
    logic             checksum_ok;
  } res_t;

endpackage

// ===== design/afd_if.sv =====
// ----------------------------------------------------------------------------
// afd_if: beat channels of the api frame deframer
// received byte channel and per-byte result channel
// ----------------------------------------------------------------------------
interface afd_rx_if;
  logic                       valid;
  logic                       ready;
  logic [afd_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afd_res_if;
  logic                       valid;
  logic                       ready;
  logic [afd_pkg::ByteW-1:0]  data_byte;
  logic [afd_pkg::PosW-1:0]   byte_position;
  logic                       frame_end;
  logic [afd_pkg::ByteW-1:0]  frame_type;
  logic [afd_pkg::ByteW-1:0]  payload_length;
  logic                       delimiter_ok;
  logic                       checksum_ok;

  modport source (output valid, output data_byte, output byte_position,
                  output frame_end, output frame_type, output payload_length,
                  output delimiter_ok, output checksum_ok, input ready);
  modport sink   (input valid, input data_byte, input byte_position,
                  input frame_end, input frame_type, input payload_length,
                  input delimiter_ok, input checksum_ok, output ready);
endinterface

// ===== design/afd_frame_core.sv =====
// ----------------------------------------------------------------------------
// afd_frame_core: frame tracking state and per-byte evaluation
// holds offset, length, type, delimiter flag and running checksum
// ----------------------------------------------------------------------------
module afd_frame_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [afd_pkg::ByteW-1:0] byte_i,
  output afd_pkg::res_t             res_o
);

  logic [afd_pkg::PosW-1:0]  pos_q, pos_d;
  logic [afd_pkg::ByteW-1:0] len_q, len_d;
  logic [afd_pkg::ByteW-1:0] sum_q, sum_d;
  logic [afd_pkg::ByteW-1:0] type_q, type_d;
  logic                      delim_q, delim_d;

  logic [afd_pkg::ByteW-1:0] len_cur, type_cur, sum_now;
  logic                      delim_cur, past_hdr, last;

  always_comb begin
    len_cur   = (pos_q == afd_pkg::PosLenLo) ? byte_i : len_q;
    type_cur  = (pos_q == afd_pkg::PosType)  ? byte_i : type_q;
    delim_cur = (pos_q == afd_pkg::PosDelim) ? (byte_i == afd_pkg::DelimValue) : delim_q;
    past_hdr  = (pos_q >= afd_pkg::PosType);
    sum_now   = past_hdr ? (sum_q + byte_i) : '0;
    last      = past_hdr &&
                (pos_q == (afd_pkg::PosW'(len_cur) + afd_pkg::PosType));

    res_o.data_byte      = byte_i;
    res_o.byte_position  = pos_q;
    res_o.frame_end      = last;
    res_o.frame_type     = last ? type_cur : '0;
    res_o.payload_length = (pos_q >= afd_pkg::PosLenLo) ? len_cur : '0;
    res_o.delimiter_ok   = last & delim_cur;
    res_o.checksum_ok    = last && (sum_now == afd_pkg::SumTarget);

    // frame end clears everything, next byte is a delimiter
    if (last) begin
      pos_d   = '0;
      len_d   = '0;
      sum_d   = '0;
      type_d  = '0;
      delim_d = 1'b0;
    end else begin
      pos_d   = pos_q + 1'b1;
      len_d   = len_cur;
      sum_d   = sum_now;
      type_d  = type_cur;
      delim_d = delim_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      type_q  <= '0;
      delim_q <= 1'b0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      type_q  <= type_d;
      delim_q <= delim_d;
    end
  end

endmodule

// ===== design/api_frame_deframer_checksum.sv =====
// ----------------------------------------------------------------------------
// api_frame_deframer_checksum: api-mode serial frame deframer
// splits a received byte stream into frames and checks each checksum
// ----------------------------------------------------------------------------
// usage
//   rx_i carries one received byte per beat; res_o returns exactly one beat
//   per received byte, in order: the byte, its offset in the frame, and on
//   the checksum byte (offset length_low + 3) the frame type, delimiter and
//   checksum verdicts. the length high byte plays no part in framing
// datapath and throughput
//   a byte accepted into the input register is evaluated into the result
//   register and then shows on res_o. one byte per cycle is taken sustained
//   while res_o is not stalled; the frame state update is one add and
//   compare per byte
// stall behavior
//   when res_o is stalled the result register holds its beat and the input
//   register still takes one more byte; rx_i.ready drops only when both are
//   full, so no beat is lost or repeated
// reset
//   rst_ni low empties both registers and returns the frame state to offset
//   zero with a cleared checksum
// ----------------------------------------------------------------------------
module api_frame_deframer_checksum (
  input  logic        clk_i,
  input  logic        rst_ni,
  afd_rx_if.sink      rx_i,
  afd_res_if.source   res_o
);

  // input register
  logic                      in_vld_q;
  logic [afd_pkg::ByteW-1:0] in_byte_q;

  // result register
  logic                      out_vld_q;
  afd_pkg::res_t             out_res_q;

  afd_pkg::res_t             eval_res;
  logic                      out_load, in_adv, in_take;

  // result register can load when empty or being drained this cycle
  assign out_load = !out_vld_q || res_o.ready;
  assign in_adv   = in_vld_q && out_load;
  assign rx_i.ready = !in_vld_q || out_load;
  assign in_take  = rx_i.valid && rx_i.ready;

  // frame state advances once per byte moved into the result register
  afd_frame_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_adv),
    .byte_i (in_byte_q),
    .res_o  (eval_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      out_res_q <= eval_res;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.data_byte      = out_res_q.data_byte;
  assign res_o.byte_position  = out_res_q.byte_position;
  assign res_o.frame_end      = out_res_q.frame_end;
  assign res_o.frame_type     = out_res_q.frame_type;
  assign res_o.payload_length = out_res_q.payload_length;
  assign res_o.delimiter_ok   = out_res_q.delimiter_ok;
  assign res_o.checksum_ok    = out_res_q.checksum_ok;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the api frame deframer
// drives received bytes into the deframer and checks every result beat
// against an in-bench frame tracker, with random idling on both channels
// ----------------------------------------------------------------------------
module tb;
  import afd_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  // 2 time unit clock period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  afd_rx_if  rx_if ();
  afd_res_if res_if ();

  api_frame_deframer_checksum u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // frame tracker: mirrors the deframer state, one update per accepted byte
  logic [PosW-1:0]  frm_pos;
  logic [ByteW-1:0] frm_len;
  logic [ByteW-1:0] frm_sum;
  logic [ByteW-1:0] frm_type;
  logic             frm_delim_ok;

  res_t expected_beats[$];
  int   n_sent;
  int   n_err;

  // idling switches for the two channels
  bit rx_gap_on;
  bit res_stall_on;

  // work out the result beat of one received byte and advance the tracker
  task automatic track_frame_byte(input logic [ByteW-1:0] b);
    logic [PosW-1:0]  pos;
    logic [ByteW-1:0] sum_now;
    logic             last;
    res_t             r;
    pos = frm_pos;
    if (pos == PosDelim) frm_delim_ok = (b == DelimValue);
    if (pos == PosLenLo) frm_len = b;
    if (pos == PosType)  frm_type = b;
    // the sum runs from the type byte through the checksum byte
    sum_now = (pos >= PosType) ? frm_sum + b : '0;
    // checksum sits at offset len + 3; the length high byte has no say
    last = (pos >= PosType) && (pos == {1'b0, frm_len} + PosType);
    r.data_byte      = b;
    r.byte_position  = pos;
    r.frame_end      = last;
    r.frame_type     = last ? frm_type : '0;
    r.payload_length = (pos >= PosLenLo) ? frm_len : '0;
    r.delimiter_ok   = last & frm_delim_ok;
    r.checksum_ok    = last && (sum_now == SumTarget);
    expected_beats.push_back(r);
    if (last) begin
      // frame done, next byte is a new delimiter
      frm_pos      = '0;
      frm_len      = '0;
      frm_sum      = '0;
      frm_type     = '0;
      frm_delim_ok = 1'b0;
    end else begin
      frm_sum = sum_now;
      frm_pos = pos + 1'b1;
    end
  endtask

  // one beat on rx: hold valid until ready, then maybe leave a gap
  task automatic send_byte(input logic [ByteW-1:0] b);
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    track_frame_byte(b);
    n_sent++;
    if (rx_gap_on && $urandom_range(0, 5) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // stop sending and wait until every expected beat has come back
  task automatic drain_results();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  // random byte; at the length offset mostly a short length
  function automatic logic [ByteW-1:0] noise_byte();
    if (frm_pos == PosLenLo && $urandom_range(0, 3) != 0)
      return ByteW'($urandom_range(0, 6));
    return ByteW'($urandom_range(0, 255));
  endfunction

  // finish whatever frame is open with random bytes
  task automatic finish_open_frame();
    while (frm_pos != PosDelim) send_byte(noise_byte());
  endtask

  // one frame of payload length len, delimiter and checksum good or broken
  task automatic send_frame(input logic [ByteW-1:0] len, input bit good_delim,
                            input bit good_cks);
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] sum;
    if (good_delim) begin
      b = DelimValue;
    end else begin
      do b = ByteW'($urandom_range(0, 255)); while (b == DelimValue);
    end
    send_byte(b);
    send_byte(ByteW'($urandom_range(0, 255)));  // length high byte, ignored
    send_byte(len);
    if (len == 0) begin
      // type byte doubles as the checksum
      if (good_cks) begin
        b = SumTarget;
      end else begin
        do b = ByteW'($urandom_range(0, 255)); while (b == SumTarget);
      end
      send_byte(b);
    end else begin
      b   = ByteW'($urandom_range(0, 255));
      sum = b;
      send_byte(b);
      repeat (int'(len) - 1) begin
        b   = ByteW'($urandom_range(0, 255));
        sum = sum + b;
        send_byte(b);
      end
      b = good_cks ? ByteW'(SumTarget - sum) : ByteW'($urandom_range(0, 255));
      send_byte(b);
    end
  endtask

  function automatic logic [ByteW-1:0] pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 2)  return '0;
    if (sel < 14) return ByteW'($urandom_range(1, 8));
    if (sel < 19) return ByteW'($urandom_range(9, 40));
    return ByteW'($urandom_range(41, 90));
  endfunction

  // receiver side: ready with random stall bursts
  initial begin : res_ready_drive
    int unsigned stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (res_stall_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (n_err < 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      n_err++;
    end
  endtask

  // compare every accepted result beat with the oldest expected one
  always @(posedge clk_i) begin : beat_check
    res_t got;
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = {res_if.data_byte, res_if.byte_position, res_if.frame_end,
             res_if.frame_type, res_if.payload_length, res_if.delimiter_ok,
             res_if.checksum_ok};
      if (expected_beats.size() == 0) begin
        if (n_err < 40)
          $display("%0t: unexpected beat, expected none, got %0h", $time, got);
        n_err++;
      end else begin
        want = expected_beats.pop_front();
        check_field("data_byte",      32'(want.data_byte),      32'(got.data_byte));
        check_field("byte_position",  32'(want.byte_position),  32'(got.byte_position));
        check_field("frame_end",      32'(want.frame_end),      32'(got.frame_end));
        check_field("frame_type",     32'(want.frame_type),     32'(got.frame_type));
        check_field("payload_length", 32'(want.payload_length),
                    32'(got.payload_length));
        check_field("delimiter_ok",   32'(want.delimiter_ok),   32'(got.delimiter_ok));
        check_field("checksum_ok",    32'(want.checksum_ok),    32'(got.checksum_ok));
      end
    end
  end

  // hand-built frames: zero length, extremes of the byte, bad delimiter,
  // ignored length high byte, and frames back to back
  task automatic test_directed_frames();
    // zero length, type byte is 0xff so the checksum holds
    send_byte(8'h7E); send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF);
    // zero length with a full high byte, checksum fails
    send_byte(8'h7E); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00);
    // bad delimiter, still framed by its length, checksum good
    send_byte(8'h00); send_byte(8'h12); send_byte(8'h01); send_byte(8'h10);
    send_byte(8'hEF);
    // a zero payload byte and a zero checksum byte after an 0xff type
    send_byte(8'h7E); send_byte(8'h80); send_byte(8'h02); send_byte(8'hFF);
    send_byte(8'h00); send_byte(8'h00);
    // all-ones delimiter and a checksum that misses
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h01); send_byte(8'h80);
    send_byte(8'h80);
    drain_results();
  endtask

  // mostly well-formed frames with random content, some noise and pauses
  task automatic test_random_frames();
    int target;
    int unsigned sel;
    target = n_sent + 700;
    while (n_sent < target) begin
      sel = $urandom_range(0, 19);
      if (sel < 3) begin
        repeat ($urandom_range(1, 6)) send_byte(noise_byte());
        finish_open_frame();
      end else if (sel == 3) begin
        drain_results();
      end else if (sel == 4) begin
        // change the idling mix to get quiet stretches too
        rx_gap_on    = $urandom_range(0, 2) != 0;
        res_stall_on = $urandom_range(0, 2) != 0;
      end else begin
        send_frame(pick_length(), $urandom_range(0, 4) != 0, $urandom_range(0, 3) != 0);
      end
    end
    drain_results();
  endtask

  // longest frame, offsets reach 258
  task automatic test_max_length_frame();
    rx_gap_on    = 1'b1;
    res_stall_on = 1'b1;
    send_frame(8'hFF, 1'b1, 1'b1);
    drain_results();
  endtask

  // closing stretch with no idling on either side
  task automatic test_back_to_back();
    int target;
    rx_gap_on    = 1'b0;
    res_stall_on = 1'b0;
    target = n_sent + 250;
    while (n_sent < target)
      send_frame(pick_length(), $urandom_range(0, 4) != 0, $urandom_range(0, 2) != 0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    frm_pos       = '0;
    frm_len       = '0;
    frm_sum       = '0;
    frm_type      = '0;
    frm_delim_ok  = 1'b0;
    n_sent        = 0;
    n_err         = 0;
    rx_gap_on     = 1'b1;
    res_stall_on  = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_random_frames();
    test_max_length_frame();
    test_back_to_back();

    drain_results();
    // catch any stray beat past the last expected one
    repeat (20) @(posedge clk_i);
    if (n_err == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #1000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
